FILE: hw/rtl/bounded_deque_with_search_defines.svh
// Assertion macros used by the deque controller
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication
`define BDQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bdq_pkg.sv
// Types and codes for the bounded deque with search
`default_nettype none

package bdq_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_FIND      = 3'd4
    } bdq_op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } bdq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } bdq_state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } bdq_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_position;
        logic [4:0] count;
    } bdq_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bdq_store.sv
// Entry store: one write port, one read port with registered read data
`default_nettype none

module bdq_store #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic signed [31:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic signed [31:0]              rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bdq_ctrl.sv
// Request sequencer: ring pointers, count, find scan and result register
`default_nettype none
`include "bounded_deque_with_search_defines.svh"

module bdq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire bdq_pkg::bdq_req_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output bdq_pkg::bdq_rsp_t               out_data,
    output logic                            mem_we,
    output logic [$clog2(DEPTH)-1:0]        mem_waddr,
    output logic signed [31:0]              mem_wdata,
    output logic [$clog2(DEPTH)-1:0]        mem_raddr,
    input  wire logic signed [31:0]         mem_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    bdq_pkg::bdq_state_t  state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic signed [31:0]   val_reg, val_next;
    logic [PTR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     scan_addr_reg, scan_addr_next;
    logic [PTR_W-1:0]     cmp_pos_reg, cmp_pos_next;
    bdq_pkg::bdq_status_t res_status_reg, res_status_next;
    logic [PTR_W-1:0]     res_pos_reg, res_pos_next;
    logic                 out_valid_reg, out_valid_next;
    bdq_pkg::bdq_rsp_t    out_data_reg, out_data_next;

    logic                 out_free;
    logic                 is_full;
    logic                 is_empty;
    logic [PTR_W-1:0]     front_dec;
    logic [PTR_W-1:0]     front_inc;
    logic [PTR_W-1:0]     scan_inc;
    logic [SUM_W-1:0]     back_sum;
    logic [PTR_W-1:0]     back_addr;
    logic                 scan_last;
    logic [31:0]          pos_wide;
    logic [31:0]          cnt_wide;
    logic                 in_scan;
    logic                 scan_in_range;
    logic                 done_fire;

    // ring index arithmetic, wraps at DEPTH for any depth
    always_comb
    begin
        front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
        front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);
        scan_inc  = (scan_addr_reg == PTR_W'(DEPTH - 1)) ? '0 : scan_addr_reg + PTR_W'(1);
        back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
        if (back_sum >= SUM_W'(DEPTH))
        begin
            back_sum = back_sum - SUM_W'(DEPTH);
        end
        back_addr = back_sum[PTR_W-1:0];
        scan_last = (CNT_W'(cmp_pos_reg) + CNT_W'(1)) == count_reg;
        is_full   = count_reg == CNT_W'(DEPTH);
        is_empty  = count_reg == '0;
        out_free  = !out_valid_reg || out_ready;
        pos_wide  = 32'(res_pos_reg);
        cnt_wide  = 32'(count_reg);
        in_scan       = state_reg == bdq_pkg::ST_SCAN;
        scan_in_range = CNT_W'(cmp_pos_reg) < count_reg;
        done_fire     = (state_reg == bdq_pkg::ST_DONE) && out_free;
    end

    // no store write can land during a scan: one request is in flight at a time
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_pos_next    = cmp_pos_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = front_dec;
        mem_wdata       = val_reg;
        mem_raddr       = scan_addr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.operation;
                    val_next   = in_data.value;
                    state_next = bdq_pkg::ST_EXEC;
                end
            end
            bdq_pkg::ST_EXEC:
            begin
                res_status_next = bdq_pkg::STS_OK;
                res_pos_next    = '0;
                state_next      = bdq_pkg::ST_DONE;
                case (op_reg)
                    bdq_pkg::OP_INS_FRONT:
                    begin
                        if (is_full)
                        begin
                            res_status_next = bdq_pkg::STS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = front_dec;
                            front_next = front_dec;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    bdq_pkg::OP_INS_BACK:
                    begin
                        if (is_full)
                        begin
                            res_status_next = bdq_pkg::STS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = back_addr;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    bdq_pkg::OP_REM_FRONT:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = bdq_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            front_next = front_inc;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    bdq_pkg::OP_REM_BACK:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = bdq_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    bdq_pkg::OP_FIND:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = bdq_pkg::STS_NOTFOUND;
                        end
                        else
                        begin
                            // read the front now, compare it next cycle
                            mem_raddr      = front_reg;
                            scan_addr_next = front_inc;
                            cmp_pos_next   = '0;
                            state_next     = bdq_pkg::ST_SCAN;
                        end
                    end
                    default:
                    begin
                        res_status_next = bdq_pkg::STS_OK;
                    end
                endcase
            end
            bdq_pkg::ST_SCAN:
            begin
                // rdata holds the entry at cmp_pos; the next read is already issued
                if (mem_rdata == val_reg)
                begin
                    res_status_next = bdq_pkg::STS_OK;
                    res_pos_next    = cmp_pos_reg;
                    state_next      = bdq_pkg::ST_DONE;
                end
                else if (scan_last)
                begin
                    res_status_next = bdq_pkg::STS_NOTFOUND;
                    res_pos_next    = '0;
                    state_next      = bdq_pkg::ST_DONE;
                end
                else
                begin
                    mem_raddr      = scan_addr_reg;
                    scan_addr_next = scan_inc;
                    cmp_pos_next   = cmp_pos_reg + PTR_W'(1);
                end
            end
            bdq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = res_status_reg;
                    out_data_next.found_position  = pos_wide[3:0];
                    out_data_next.count           = cnt_wide[4:0];
                    state_next                    = bdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        scan_addr_reg  <= scan_addr_next;
        cmp_pos_reg    <= cmp_pos_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_data_reg   <= out_data_next;
    end

    assign in_ready  = state_reg == bdq_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BDQ_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count above depth")
    `BDQ_ASSERT_IMPLY(a_write_in_exec, mem_we, state_reg == bdq_pkg::ST_EXEC, "write outside exec")
    `BDQ_ASSERT_IMPLY(a_scan_nonempty, in_scan, !is_empty && scan_in_range, "scan past count")
    `BDQ_ASSERT_NEXT(a_done_loads_out, done_fire, out_valid_reg && in_ready, "result not loaded")

endmodule

`default_nettype wire

FILE: hw/rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with linear search
//
//  channel | direction | handshake           | payload
//  in      | request   | in_valid / in_ready   | bdq_req_t (operation, value)
//  out     | result    | out_valid / out_ready | bdq_rsp_t (status, found_position, count)
//
// Insert, remove and undefined codes pass from accept through the execute and done
// states to the output register. Find on an empty deque does the same; otherwise
// the scan stops at the first hit or after the last entry, comparing one entry per
// cycle through the single read port of the entry store.
// One request in flight; the next request is taken while a result waits in
// the output register. Reset clears pointers and count; no clearing pass.
`default_nettype none

module bounded_deque_with_search #(
    parameter int DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bdq_pkg::bdq_req_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bdq_pkg::bdq_rsp_t       out_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                   mem_we;
    logic [PTR_W-1:0]       mem_waddr;
    logic signed [31:0]     mem_wdata;
    logic [PTR_W-1:0]       mem_raddr;
    logic signed [31:0]     mem_rdata;

    bdq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdq_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: test/bounded_deque_with_search_check.sv
// Checker for the bounded deque: predicts each result and compares it with the block output
`default_nettype none

module bounded_deque_with_search_check #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire bdq_pkg::bdq_req_t in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire bdq_pkg::bdq_rsp_t out_data,
    output int                     errors,
    output int                     pending
);

    localparam int REPORT_MAX = 10;

    // shadow copy of the ring
    logic signed [31:0] shadow_ring [DEPTH];
    int unsigned        shadow_head;
    int unsigned        shadow_held;

    bdq_pkg::bdq_rsp_t rsp_expected_q [$];

    function automatic bdq_pkg::bdq_rsp_t deque_apply(bdq_pkg::bdq_req_t req);
        bdq_pkg::bdq_status_t st;
        int unsigned          pos;
        bit                   hit;
        bdq_pkg::bdq_rsp_t    rsp;
        st  = bdq_pkg::STS_OK;
        pos = 0;
        hit = 1'b0;
        case (req.operation)
            bdq_pkg::OP_INS_FRONT:
            begin
                if (shadow_held >= DEPTH)
                begin
                    st = bdq_pkg::STS_FULL;
                end
                else
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = req.value;
                    shadow_held++;
                end
            end
            bdq_pkg::OP_INS_BACK:
            begin
                if (shadow_held >= DEPTH)
                begin
                    st = bdq_pkg::STS_FULL;
                end
                else
                begin
                    shadow_ring[(shadow_head + shadow_held) % DEPTH] = req.value;
                    shadow_held++;
                end
            end
            bdq_pkg::OP_REM_FRONT:
            begin
                if (shadow_held == 0)
                begin
                    st = bdq_pkg::STS_EMPTY;
                end
                else
                begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_held--;
                end
            end
            bdq_pkg::OP_REM_BACK:
            begin
                if (shadow_held == 0)
                begin
                    st = bdq_pkg::STS_EMPTY;
                end
                else
                begin
                    shadow_held--;
                end
            end
            bdq_pkg::OP_FIND:
            begin
                st = bdq_pkg::STS_NOTFOUND;
                // first match from the front wins
                for (int unsigned i = 0; i < shadow_held; i++)
                begin
                    if (!hit && shadow_ring[(shadow_head + i) % DEPTH] == req.value)
                    begin
                        hit = 1'b1;
                        st  = bdq_pkg::STS_OK;
                        pos = i;
                    end
                end
            end
            default: ;  // reserved codes: no state change
        endcase
        rsp.status         = st;
        rsp.found_position = pos[3:0];
        rsp.count          = shadow_held[4:0];
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bdq_pkg::bdq_rsp_t want;
        if (!rst_n)
        begin
            shadow_head = 0;
            shadow_held = 0;
            rsp_expected_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // result first: it can only belong to an earlier request
            if (out_valid && out_ready)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $display("mismatch: unexpected result status=%0d pos=%0d count=%0d",
                                 out_data.status, out_data.found_position, out_data.count);
                    errors <= errors + 1;
                end
                else
                begin
                    want = rsp_expected_q.pop_front();
                    if (out_data !== want)
                    begin
                        if (errors < REPORT_MAX)
                            $display({"mismatch: expected status=%0d pos=%0d count=%0d,",
                                      " got status=%0d pos=%0d count=%0d"},
                                     want.status, want.found_position, want.count,
                                     out_data.status, out_data.found_position, out_data.count);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                rsp_expected_q.push_back(deque_apply(in_data));
            pending <= rsp_expected_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/bounded_deque_with_search_test.sv
// Testbench top for the bounded deque: drives requests and results handshakes, gives the verdict
`default_nettype none

module bounded_deque_with_search_test;

    localparam int          DEPTH         = 16;
    localparam int          RANDOM_ITEMS  = 1900;
    localparam int          CALM_ITEMS    = 200;
    localparam int          STALL_LIMIT   = 2000;
    localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SEARCH } mix_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    bdq_pkg::bdq_req_t in_data;
    logic              out_valid;
    logic              out_ready;
    bdq_pkg::bdq_rsp_t out_data;
    int                errors;
    int                pending;
    bit                calm = 1'b0;
    int                stall_cycles = 0;

    // values that recur often so finds hit, including duplicates
    logic signed [31:0] value_pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
                                           32'shffff_ffff, 32'sh0000_0001, 32'sh0000_0005,
                                           32'sh5555_5555, 32'shaaaa_aaaa};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bounded_deque_with_search #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    bounded_deque_with_search_check #(.DEPTH(DEPTH)) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_op(mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        case (mix)
            MIX_FILL:   roll = (roll < 72) ? 0 : (roll < 90) ? 2 : 1;
            MIX_DRAIN:  roll = (roll < 22) ? 0 : (roll < 40) ? 2 : 1;
            MIX_EVEN:   roll = (roll < 40) ? 0 : (roll < 70) ? 1 : 2;
            default:    roll = (roll < 25) ? 0 : (roll < 40) ? 1 : 2;
        endcase
        // 0 insert, 1 remove, 2 find
        if (roll == 0)
            return $urandom_range(0, 1) ? bdq_pkg::OP_INS_BACK : bdq_pkg::OP_INS_FRONT;
        if (roll == 1)
            return $urandom_range(0, 1) ? bdq_pkg::OP_REM_BACK : bdq_pkg::OP_REM_FRONT;
        return bdq_pkg::OP_FIND;
    endfunction

    // hold the request until accepted, then maybe pause
    task automatic send(input logic [2:0] op, input logic signed [31:0] val);
        bdq_pkg::bdq_req_t req;
        req.operation = op;
        req.value     = val;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // result side: random stall bursts, none once calm
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int   left;
        int   burst;
        mix_t mix;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sequence corner cases
        send(bdq_pkg::OP_FIND, 32'sh0000_0000);
        send(bdq_pkg::OP_REM_FRONT, $urandom);
        send(bdq_pkg::OP_REM_BACK, $urandom);
        send(OP_RSVD_FIRST, $urandom);
        // extremes at both ends, then look them up
        send(bdq_pkg::OP_INS_BACK, 32'sh7fff_ffff);
        send(bdq_pkg::OP_INS_FRONT, 32'sh8000_0000);
        send(bdq_pkg::OP_INS_BACK, 32'sh0000_0000);
        send(bdq_pkg::OP_INS_FRONT, 32'shffff_ffff);
        send(bdq_pkg::OP_FIND, 32'sh7fff_ffff);
        send(bdq_pkg::OP_FIND, 32'sh8000_0000);
        send(bdq_pkg::OP_FIND, 32'shffff_ffff);
        send(bdq_pkg::OP_FIND, 32'sh0000_0000);
        send(bdq_pkg::OP_FIND, 32'sh0001_2345);
        for (logic [3:0] op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
            send(op[2:0], $urandom);
        send(bdq_pkg::OP_REM_BACK, $urandom);
        send(bdq_pkg::OP_REM_FRONT, $urandom);
        send(bdq_pkg::OP_FIND, 32'sh0000_0000);
        send(bdq_pkg::OP_FIND, 32'sh7fff_ffff);

        left = RANDOM_ITEMS;
        while (left > 0)
        begin
            mix   = mix_t'($urandom_range(0, 3));
            burst = $urandom_range(20, 80);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                if (left <= CALM_ITEMS)
                    calm = 1'b1;
                send(pick_op(mix), pick_value());
                left--;
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_store.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_deque_with_search.sv
test/bounded_deque_with_search_check.sv
test/bounded_deque_with_search_test.sv
